// ===== src/srng_pkg.sv =====
`default_nettype none

package srng_pkg;

    // Field widths fixed by the gain, threshold and coefficient formats.
    localparam int ENV_W   = 33;
    localparam int GAIN_W  = 24;
    localparam int ALPHA_W = 24;
    localparam int THR_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W  = 4;

    localparam logic [GAIN_W-1:0]  GAIN_UNITY      = 24'd8388608;
    localparam logic [GAIN_W-1:0]  GAIN_PASS_LIMIT = 24'd8380220;
    localparam logic [ALPHA_W:0]   ALPHA_ONE       = 25'd16777216;

    localparam logic [THR_W-1:0]   OPEN_THR_RESET  = 32'd429497;
    localparam logic [THR_W-1:0]   CLOSE_THR_RESET = 32'd170986;
    localparam logic [ALPHA_W-1:0] ENV_ALPHA_RESET = 24'd16707457;
    localparam logic [ALPHA_W-1:0] REL_ALPHA_RESET = 24'd16770227;

    localparam logic [CFG_IDX_W-1:0] REG_GATE_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_THR_SQ  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_THR_SQ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_ALPHA    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REL_ALPHA    = 3'd4;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        acc_op_t op;
    } mac_ctl_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SQ_L,
        MUL_SQ_R,
        MUL_ENV,
        MUL_XSQ,
        MUL_DECAY,
        MUL_SCALE_L,
        MUL_SCALE_R
    } mul_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_XSQ,
        WR_ENV,
        WR_GAIN,
        WR_OUT_L,
        WR_OUT_R
    } wr_sel_t;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_DISABLED,
        JMP_PASS
    } jmp_t;

    typedef struct packed {
        mul_sel_t          mul;
        acc_op_t           acc;
        wr_sel_t           wr;
        jmp_t              jmp;
        logic [STEP_W-1:0] target;
        logic              last;
    } ucode_t;

    localparam logic [STEP_W-1:0] END_STEP = 4'd9;

    // Control program, one word per step.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{mul: MUL_NONE, acc: ACC_HOLD, wr: WR_NONE, jmp: JMP_NONE,
              target: END_STEP, last: 1'b0};
        unique case (step)
            4'd0: begin
                w.mul = MUL_SQ_L;
                w.acc = ACC_LOAD;
                w.jmp = JMP_DISABLED;
            end
            4'd1: begin
                w.mul = MUL_SQ_R;
                w.acc = ACC_ADD;
            end
            4'd2: begin
                w.mul = MUL_ENV;
                w.acc = ACC_LOAD;
                w.wr  = WR_XSQ;
            end
            4'd3: begin
                w.mul = MUL_XSQ;
                w.acc = ACC_ADD;
            end
            4'd4: begin
                w.mul = MUL_DECAY;
                w.acc = ACC_LOAD;
                w.wr  = WR_ENV;
            end
            4'd5: begin
                w.wr = WR_GAIN;
            end
            4'd6: begin
                w.mul = MUL_SCALE_L;
                w.acc = ACC_LOAD;
                w.jmp = JMP_PASS;
            end
            4'd7: begin
                w.mul = MUL_SCALE_R;
                w.acc = ACC_LOAD;
                w.wr  = WR_OUT_L;
            end
            4'd8: begin
                w.wr = WR_OUT_R;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/srng_mac.sv =====
`default_nettype none

// Shared multiplier with an accumulator behind it.
module srng_mac #(
    parameter int A_W   = 33,
    parameter int B_W   = 25,
    parameter int ACC_W = 57
) (
    input  wire logic                 aclk,
    input  wire srng_pkg::mac_ctl_t   ctl,
    input  wire logic [A_W-1:0]       op_a,
    input  wire logic [B_W-1:0]       op_b,
    output logic      [ACC_W-1:0]     acc
);

    logic [A_W+B_W-1:0] prod;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;

    assign prod = {{B_W{1'b0}}, op_a} * {{A_W{1'b0}}, op_b};

    always_comb begin
        unique case (ctl.op)
            srng_pkg::ACC_LOAD: acc_next = prod[ACC_W-1:0];
            srng_pkg::ACC_ADD:  acc_next = acc_reg + prod[ACC_W-1:0];
            default:            acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== src/stereo_rms_noise_gate_top.sv =====
`default_nettype none

// Stereo noise gate driven by a mean-square envelope with open/close hysteresis. Each request on
// the input stream carries one left/right pair of signed Q1.(SAMPLE_BITS-1) samples and yields
// exactly one result with the gated pair, the gate state and the Q1.23 gain now in force. The
// block works on one pair at a time: once a pair is taken, a ten-step control program runs on a
// single shared multiplier and accumulator; the samples are scaled when the gain is below 0.999
// and pass unscaled otherwise, and the program jumps to its final step while the gate is
// disabled. The result sits in an output register, so the next pair is taken while the
// previous result still waits; the program only stalls on its final step if the output
// register is still full. Configuration registers are written through the cfg port, which
// never stalls; writes are expected only while the block is idle, and indices beyond the last
// register are ignored. SAMPLE_BITS may range from 16 to 32.
module stereo_rms_noise_gate_top #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic                                        s_tvalid,
    output logic                                             s_tready,
    // Fields from bit 0: left_in, right_in, zero padding.
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]          s_tdata,

    output logic                                             m_tvalid,
    input  wire logic                                        m_tready,
    // Fields from bit 0: left_out, right_out, applied_gain, zero padding.
    output logic [((2*SAMPLE_BITS+srng_pkg::GAIN_W+7)/8)*8-1:0] m_tdata,
    // Fields from bit 0: is_open.
    output logic                                             m_tuser,

    input  wire logic                                        cfg_valid,
    output logic                                             cfg_ready,
    input  wire logic [srng_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  wire logic [srng_pkg::CFG_DATA_W-1:0]             cfg_data
);

    localparam int SB       = SAMPLE_BITS;
    localparam int M_DATA_W = ((2*SB+srng_pkg::GAIN_W+7)/8)*8;
    localparam int A_W      = srng_pkg::ENV_W;
    localparam int B_W      = (SB > srng_pkg::ALPHA_W+1) ? SB : srng_pkg::ALPHA_W+1;
    localparam int ACC_W    = (2*SB > 57) ? 2*SB : 57;
    // Sum of squares is brought to Q1.32 (the halving of the pair's power included).
    localparam int SQ_SHIFT = 2*SB - 33;
    localparam int SH_R     = (SQ_SHIFT > 0) ? SQ_SHIFT : 0;
    localparam int SH_L     = (SQ_SHIFT < 0) ? -SQ_SHIFT : 0;
    localparam logic [ACC_W-1:0] ENV_ROUND   = ACC_W'(1) << 23;
    localparam logic [ACC_W-1:0] SCALE_ROUND = ACC_W'(1) << 22;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Control and architectural state.
    state_t                                state_reg;
    logic [srng_pkg::STEP_W-1:0]           step_reg;
    logic                                  m_tvalid_reg;
    logic                                  gate_enable_reg;
    logic [srng_pkg::THR_W-1:0]            open_thr_reg;
    logic [srng_pkg::THR_W-1:0]            close_thr_reg;
    logic [srng_pkg::ALPHA_W-1:0]          env_alpha_reg;
    logic [srng_pkg::ALPHA_W-1:0]          rel_alpha_reg;
    logic [srng_pkg::ENV_W-1:0]            env_reg;
    logic [srng_pkg::GAIN_W-1:0]           gain_reg;
    logic                                  open_reg;

    // Working registers of the current pair.
    logic [SB-1:0]                         mag_l_reg;
    logic [SB-1:0]                         mag_r_reg;
    logic                                  neg_l_reg;
    logic                                  neg_r_reg;
    logic [SB-1:0]                         out_l_reg;
    logic [SB-1:0]                         out_r_reg;
    logic [srng_pkg::ENV_W-1:0]            xsq_reg;
    logic [M_DATA_W-1:0]                   m_tdata_reg;
    logic                                  m_tuser_reg;

    logic [SB-1:0]                         in_l;
    logic [SB-1:0]                         in_r;
    logic                                  accept;
    logic                                  running;
    logic                                  deliver;
    srng_pkg::ucode_t                      uw;
    srng_pkg::mac_ctl_t                    mac_ctl;
    logic [A_W-1:0]                        op_a;
    logic [B_W-1:0]                        op_b;
    logic [ACC_W-1:0]                      acc;
    logic                                  jump_taken;
    logic [srng_pkg::STEP_W-1:0]           step_next;

    logic [srng_pkg::ENV_W-1:0]            xsq_next;
    logic [ACC_W-1:0]                      env_sum;
    logic [srng_pkg::ENV_W-1:0]            env_next;
    logic                                  open_next;
    logic [srng_pkg::GAIN_W-1:0]           gain_next;
    logic [ACC_W-1:0]                      scale_sum;
    logic [SB-1:0]                         scale_mag;
    logic [SB-1:0]                         out_l_next;
    logic [SB-1:0]                         out_r_next;

    assign in_l      = s_tdata[SB-1:0];
    assign in_r      = s_tdata[2*SB-1:SB];
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign running   = (state_reg == ST_RUN);
    assign uw        = srng_pkg::ucode_rom(step_reg);
    // The final step hands the result over once the output register is free.
    assign deliver   = running && uw.last && (!m_tvalid_reg || m_tready);

    assign mac_ctl.op = running ? uw.acc : srng_pkg::ACC_HOLD;

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (uw.mul)
            srng_pkg::MUL_SQ_L: begin
                op_a = A_W'(mag_l_reg);
                op_b = B_W'(mag_l_reg);
            end
            srng_pkg::MUL_SQ_R: begin
                op_a = A_W'(mag_r_reg);
                op_b = B_W'(mag_r_reg);
            end
            srng_pkg::MUL_ENV: begin
                op_a = A_W'(env_reg);
                op_b = B_W'(env_alpha_reg);
            end
            srng_pkg::MUL_XSQ: begin
                op_a = A_W'(xsq_reg);
                op_b = B_W'(srng_pkg::ALPHA_ONE - {1'b0, env_alpha_reg});
            end
            srng_pkg::MUL_DECAY: begin
                op_a = A_W'(gain_reg);
                op_b = B_W'(rel_alpha_reg);
            end
            srng_pkg::MUL_SCALE_L: begin
                op_a = A_W'(mag_l_reg);
                op_b = B_W'(gain_reg);
            end
            srng_pkg::MUL_SCALE_R: begin
                op_a = A_W'(mag_r_reg);
                op_b = B_W'(gain_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    srng_mac #(
        .A_W   (A_W),
        .B_W   (B_W),
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk (aclk),
        .ctl  (mac_ctl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    // Sequencing: a step either falls through or jumps to its target.
    always_comb begin
        unique case (uw.jmp)
            srng_pkg::JMP_DISABLED: jump_taken = !gate_enable_reg;
            srng_pkg::JMP_PASS:     jump_taken = (gain_reg >= srng_pkg::GAIN_PASS_LIMIT);
            default:                jump_taken = 1'b0;
        endcase
        step_next = jump_taken ? uw.target : step_reg + 1'b1;
    end

    // Write-back values taken from the accumulator.
    always_comb begin
        xsq_next  = srng_pkg::ENV_W'((acc >> SH_R) << SH_L);
        env_sum   = acc + ENV_ROUND;
        env_next  = env_sum[24 +: srng_pkg::ENV_W];
        if (open_reg) begin
            open_next = !(env_next < {1'b0, close_thr_reg});
        end else begin
            open_next = (env_next > {1'b0, open_thr_reg});
        end
        gain_next  = open_reg ? srng_pkg::GAIN_UNITY : acc[24 +: srng_pkg::GAIN_W];
        scale_sum  = acc + SCALE_ROUND;
        scale_mag  = scale_sum[23 +: SB];
        out_l_next = neg_l_reg ? (~scale_mag + 1'b1) : scale_mag;
        out_r_next = neg_r_reg ? (~scale_mag + 1'b1) : scale_mag;
    end

    // Payload registers of the pair in flight.
    always_ff @(posedge aclk) begin
        if (accept) begin
            mag_l_reg <= in_l[SB-1] ? (~in_l + 1'b1) : in_l;
            mag_r_reg <= in_r[SB-1] ? (~in_r + 1'b1) : in_r;
            neg_l_reg <= in_l[SB-1];
            neg_r_reg <= in_r[SB-1];
            out_l_reg <= in_l;
            out_r_reg <= in_r;
        end else if (running) begin
            if (uw.wr == srng_pkg::WR_XSQ) begin
                xsq_reg <= xsq_next;
            end
            if (uw.wr == srng_pkg::WR_OUT_L) begin
                out_l_reg <= out_l_next;
            end
            if (uw.wr == srng_pkg::WR_OUT_R) begin
                out_r_reg <= out_r_next;
            end
        end
    end

    // Control state, configuration, gate state and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
            gate_enable_reg <= 1'b0;
            open_thr_reg    <= srng_pkg::OPEN_THR_RESET;
            close_thr_reg   <= srng_pkg::CLOSE_THR_RESET;
            env_alpha_reg   <= srng_pkg::ENV_ALPHA_RESET;
            rel_alpha_reg   <= srng_pkg::REL_ALPHA_RESET;
            env_reg         <= '0;
            gain_reg        <= srng_pkg::GAIN_UNITY;
            open_reg        <= 1'b1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    srng_pkg::REG_GATE_ENABLE:  gate_enable_reg <= cfg_data[0];
                    srng_pkg::REG_OPEN_THR_SQ:  open_thr_reg    <= cfg_data;
                    srng_pkg::REG_CLOSE_THR_SQ: close_thr_reg   <= cfg_data;
                    srng_pkg::REG_ENV_ALPHA:
                        env_alpha_reg <= cfg_data[srng_pkg::ALPHA_W-1:0];
                    srng_pkg::REG_REL_ALPHA:
                        rel_alpha_reg <= cfg_data[srng_pkg::ALPHA_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (m_tvalid_reg && m_tready && !deliver) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    step_reg <= '0;
                    if (accept) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (uw.wr == srng_pkg::WR_ENV) begin
                        env_reg  <= env_next;
                        open_reg <= open_next;
                    end
                    if (uw.wr == srng_pkg::WR_GAIN) begin
                        gain_reg <= gain_next;
                    end
                    if (uw.last) begin
                        if (deliver) begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= M_DATA_W'({gain_reg, out_r_reg, out_l_reg});
                            m_tuser_reg  <= open_reg;
                            state_reg    <= ST_IDLE;
                            step_reg     <= '0;
                        end
                    end else begin
                        step_reg <= step_next;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // An accepted pair keeps the input closed for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input taken again straight after a pair was accepted");

    // Between pairs an open gate always carries unity gain.
    a_open_unity: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && open_reg) |-> (gain_reg == srng_pkg::GAIN_UNITY))
        else $error("gate open but gain not at unity");

    // The envelope never rises above 1.0 in Q1.32.
    a_env_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        env_reg <= {1'b1, {(srng_pkg::ENV_W-1){1'b0}}})
        else $error("envelope above unity");

    // A result reporting an open gate reports unity gain.
    a_result_open_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (m_tdata[2*SB +: srng_pkg::GAIN_W] == srng_pkg::GAIN_UNITY))
        else $error("result open with gain below unity");

    // The program only hands over a result from its final step.
    a_deliver_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(running && uw.last))
        else $error("result raised outside the final step");

endmodule

`default_nettype wire
